// File: design/rrts_pkg.sv
// Shared types and codes for the round-robin task scheduler.
package rrts_pkg;

   localparam int KIND_W   = 2;
   localparam int ENTRY_W  = 32;
   localparam int STATUS_W = 2;
   localparam int ID_W     = 6;

   localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_YIELD  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXIT   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NULL  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic start;
      logic step;
   } scan_ctrl_type;

   typedef struct packed {
      logic hit;
      logic last;
   } scan_stat_type;

endpackage

// File: design/rrts_req_if.sv
// Event request channel.
interface rrts_req_if import rrts_pkg::*;;
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ENTRY_W-1:0]  entry_address;

   modport source (output valid, kind, entry_address, input ready);
   modport sink   (input valid, kind, entry_address, output ready);
endinterface

// File: design/rrts_rsp_if.sv
// Scheduling result channel.
interface rrts_rsp_if import rrts_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     task_id;
   logic                switched;
   logic [ID_W-1:0]     previous_id;

   modport source (output valid, status, task_id, switched, previous_id, input ready);
   modport sink   (input valid, status, task_id, switched, previous_id, output ready);
endinterface

// File: design/rrts_scan.sv
// Round-robin slot scanner: visits one candidate slot per cycle while start or step is set.
module rrts_scan import rrts_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  scan_ctrl_type                    ctrl,
   input  logic [$clog2(SLOTS)-1:0]         start_id,
   input  logic [$clog2(SLOTS+1)-1:0]       count,
   input  logic [SLOTS-1:0]                 mask,
   output logic [$clog2(SLOTS)-1:0]         cand,
   output scan_stat_type                    stat
);
   localparam int IdxW = $clog2(SLOTS);
   localparam int CntW = $clog2(SLOTS + 1);

   logic [IdxW-1:0] cand_ff, cand_in;
   logic [CntW-1:0] left_ff, left_in;
   logic [IdxW-1:0] base;
   logic [CntW-1:0] base_inc;

   // Next slot modulo the task count
   always_comb begin
      base     = ctrl.start ? start_id : cand_ff;
      base_inc = CntW'(base) + CntW'(1);
      cand_in  = cand_ff;
      left_in  = left_ff;
      if (ctrl.start) begin
         cand_in = (base_inc == count) ? '0 : base_inc[IdxW-1:0];
         left_in = count - CntW'(1);
      end else if (ctrl.step) begin
         cand_in = (base_inc == count) ? '0 : base_inc[IdxW-1:0];
         left_in = left_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
         left_ff <= '0;
      end else begin
         cand_ff <= cand_in;
         left_ff <= left_in;
      end
   end

   assign cand      = cand_ff;
   assign stat.hit  = mask[cand_ff];
   assign stat.last = (left_ff == CntW'(1));

endmodule

// File: design/round_robin_task_scheduler.sv
// Round-robin task scheduler: keeps an active bit per task slot, a count of
// created tasks and the current task, and answers each create, yield or exit
// event with one result. The block handles one event at a time and is not
// ready from acceptance until its result has been transferred. Create and an
// unused kind give their result in the cycle after acceptance, as do yield
// and exit when only one task has been created. Otherwise yield and exit run
// the shared slot scanner, which tests one candidate slot per cycle in
// round-robin order and visits at most task count - 1 slots. After each
// result transfer the block returns to idle, where it takes the next event.
module round_robin_task_scheduler import rrts_pkg::*; #(
   parameter int TASK_SLOTS = 8
) (
   input  logic       clock,
   input  logic       reset,
   rrts_req_if.sink   req_ch,
   rrts_rsp_if.source rsp_ch
);
   localparam int IdxW = $clog2(TASK_SLOTS);
   localparam int CntW = $clog2(TASK_SLOTS + 1);

   state_type            state_ff, state_in;
   logic [TASK_SLOTS-1:0] mask_ff, mask_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic [IdxW-1:0]      cur_ff, cur_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic                 sw_ff, sw_in;
   logic [ID_W-1:0]      prev_ff, prev_in;

   logic                 accept;
   logic                 is_sched;
   logic                 need_scan;
   scan_ctrl_type        scan_ctrl;
   scan_stat_type        scan_stat;
   logic [IdxW-1:0]      scan_cand;

   assign accept    = req_ch.valid && req_ch.ready;
   assign is_sched  = req_ch.kind inside {KIND_YIELD, KIND_EXIT};
   assign need_scan = is_sched && (count_ff > CntW'(1));

   rrts_scan #(
      .SLOTS (TASK_SLOTS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (scan_ctrl),
      .start_id (cur_ff),
      .count    (count_ff),
      .mask     (mask_ff),
      .cand     (scan_cand),
      .stat     (scan_stat)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = need_scan ? ST_SCAN : ST_RESP;
            end
         end
         ST_SCAN: begin
            if (scan_stat.hit || scan_stat.last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and handshake outputs
   always_comb begin
      mask_in   = mask_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      status_in = status_ff;
      id_in     = id_ff;
      sw_in     = sw_ff;
      prev_in   = prev_ff;
      scan_ctrl = '0;
      req_ch.ready = 1'b0;
      rsp_ch.valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (accept) begin
               prev_in   = ID_W'(cur_ff);
               id_in     = ID_W'(cur_ff);
               sw_in     = 1'b0;
               status_in = STATUS_OK;
               scan_ctrl.start = need_scan;
               case (req_ch.kind)
                  KIND_CREATE: begin
                     if (count_ff >= CntW'(TASK_SLOTS)) begin
                        status_in = STATUS_FULL;
                     end else if (req_ch.entry_address == '0) begin
                        status_in = STATUS_NULL;
                     end else begin
                        id_in = ID_W'(count_ff);
                        mask_in[count_ff[IdxW-1:0]] = 1'b1;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  KIND_EXIT: begin
                     mask_in[cur_ff] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_stat.hit) begin
               // candidates never include the current slot, so a hit is a switch
               cur_in = scan_cand;
               id_in  = ID_W'(scan_cand);
               sw_in  = 1'b1;
            end else if (!scan_stat.last) begin
               scan_ctrl.step = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_ch.valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mask_ff  <= TASK_SLOTS'(1);
         count_ff <= CntW'(1);
         cur_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mask_ff  <= mask_in;
         count_ff <= count_in;
         cur_ff   <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      id_ff     <= id_in;
      sw_ff     <= sw_in;
      prev_ff   <= prev_in;
   end

   assign rsp_ch.status      = status_ff;
   assign rsp_ch.task_id     = id_ff;
   assign rsp_ch.switched    = sw_ff;
   assign rsp_ch.previous_id = prev_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the round-robin task scheduler: create, yield and exit events.
module tb_top;
   import rrts_pkg::*;

   localparam int SLOTS      = 8;
   localparam int RAND_ITEMS = 450;
   localparam int STALL_MAX  = 2000;

   // kind 3 has no operation behind it
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     task_id;
      logic                switched;
      logic [ID_W-1:0]     previous_id;
   } sched_outcome_type;

   class task_table_tracker;
      logic [SLOTS-1:0]  active;
      int unsigned       created;
      int unsigned       current;
      sched_outcome_type awaited[$];
      int unsigned       mismatches;

      function new();
         active     = 1;
         created    = 1;
         current    = 0;
         mismatches = 0;
      endfunction

      function int unsigned live_tasks();
         return $countones(active);
      endfunction

      // first active slot after the current one, modulo the created count
      function bit rotate();
         int unsigned i;
         int unsigned cand;
         if (created <= 1) return 1'b0;
         for (i = 1; i < created; i++) begin
            cand = (current + i) % created;
            if (active[cand]) begin
               current = cand;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_event(logic [KIND_W-1:0] kind, logic [ENTRY_W-1:0] entry);
         sched_outcome_type o;
         o.status      = STATUS_OK;
         o.switched    = 1'b0;
         o.previous_id = ID_W'(current);
         o.task_id     = ID_W'(current);
         case (kind)
            KIND_CREATE: begin
               // full check ranks above the null check
               if (created >= SLOTS) begin
                  o.status = STATUS_FULL;
               end else if (entry == '0) begin
                  o.status = STATUS_NULL;
               end else begin
                  o.task_id       = ID_W'(created);
                  active[created] = 1'b1;
                  created++;
               end
            end
            KIND_YIELD: begin
               o.switched = rotate();
               o.task_id  = ID_W'(current);
            end
            KIND_EXIT: begin
               active[current] = 1'b0;
               o.switched      = rotate();
               o.task_id       = ID_W'(current);
            end
            default: ;
         endcase
         awaited.push_back(o);
      endfunction

      function void report(string field, int unsigned exp, int unsigned act);
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp, act);
      endfunction

      function void check_result(sched_outcome_type got);
         sched_outcome_type exp;
         if (awaited.size() == 0) begin
            mismatches++;
            $display({"%0t: result with nothing awaited, actual status %0d task_id %0d",
                      " switched %0d previous_id %0d"},
                     $time, got.status, got.task_id, got.switched, got.previous_id);
            return;
         end
         exp = awaited.pop_front();
         if (got.status !== exp.status) report("status", exp.status, got.status);
         if (got.task_id !== exp.task_id) report("task_id", exp.task_id, got.task_id);
         if (got.switched !== exp.switched) report("switched", exp.switched, got.switched);
         if (got.previous_id !== exp.previous_id)
            report("previous_id", exp.previous_id, got.previous_id);
      endfunction

      function void check_drained();
         if (awaited.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived, expected status %0d task_id %0d",
                     $time, awaited.size(), awaited[0].status, awaited[0].task_id);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic steady;

   rrts_req_if req_ch ();
   rrts_rsp_if rsp_ch ();

   round_robin_task_scheduler #(
      .TASK_SLOTS(SLOTS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   task_table_tracker tracker = new();

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: check on transfer, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_result({rsp_ch.status, rsp_ch.task_id, rsp_ch.switched,
                               rsp_ch.previous_id});
      end
      rsp_ch.ready <= !reset && (steady || $urandom_range(99) >= 33);
   end

   task automatic send_event(input logic [KIND_W-1:0] kind, input logic [ENTRY_W-1:0] entry);
      while (!steady && $urandom_range(99) < 33) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.kind          <= kind;
      req_ch.entry_address <= entry;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_event(kind, entry);
   endtask

   task automatic send_random_event();
      int unsigned pick;
      int unsigned exit_bound;
      pick       = $urandom_range(99);
      // keep exits rare once few tasks are left alive, so yields keep rotating
      exit_bound = (tracker.live_tasks() > 2) ? 38 : 21;
      if (pick < 15)
         send_event(KIND_CREATE, ($urandom_range(3) == 0) ? '0 : ENTRY_W'($urandom));
      else if (pick < 20)
         send_event(KIND_UNUSED, ENTRY_W'($urandom));
      else if (pick < exit_bound)
         send_event(KIND_EXIT, ENTRY_W'($urandom));
      else
         send_event(KIND_YIELD, ENTRY_W'($urandom));
   endtask

   initial begin
      int i;
      reset                <= 1'b1;
      steady               <= 1'b0;
      req_ch.valid         <= 1'b0;
      req_ch.kind          <= KIND_CREATE;
      req_ch.entry_address <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single task, unused kind, null entry, exit of the only task
      send_event(KIND_YIELD, 32'h1234_5678);
      send_event(KIND_UNUSED, 32'hFFFF_FFFF);
      send_event(KIND_CREATE, 32'h0000_0000);
      send_event(KIND_EXIT, 32'h0000_0000);
      send_event(KIND_YIELD, 32'hFFFF_FFFF);
      // create after exit, yield away from an inactive current task
      send_event(KIND_CREATE, 32'hFFFF_FFFF);
      send_event(KIND_YIELD, 32'h0000_0000);
      send_event(KIND_EXIT, 32'hFFFF_FFFF);
      send_event(KIND_YIELD, 32'h0000_0001);
      send_event(KIND_CREATE, 32'h0000_0001);
      send_event(KIND_CREATE, 32'h8000_0000);
      send_event(KIND_YIELD, 32'h5555_5555);
      send_event(KIND_EXIT, 32'hAAAA_AAAA);
      send_event(KIND_YIELD, 32'h0000_0000);
      // fill the table, then full ahead of null
      send_event(KIND_CREATE, 32'hAAAA_AAAA);
      send_event(KIND_CREATE, 32'h5555_5555);
      send_event(KIND_CREATE, 32'h7FFF_FFFF);
      send_event(KIND_CREATE, 32'hFFFF_FFFE);
      send_event(KIND_CREATE, 32'h0000_0000);
      send_event(KIND_CREATE, 32'hFFFF_FFFF);
      send_event(KIND_UNUSED, 32'h0000_0000);
      send_event(KIND_YIELD, 32'hFFFF_FFFF);
      send_event(KIND_EXIT, 32'h0000_0000);

      for (i = 0; i < RAND_ITEMS; i++) begin
         if (i == 100) begin
            req_ch.valid <= 1'b0;
            while (tracker.awaited.size() != 0) @(posedge clock);
         end
         if (i == 250) steady <= 1'b1;
         if (i == 350) steady <= 1'b0;
         send_random_event();
      end
      req_ch.valid <= 1'b0;

      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      tracker.check_drained();
      if (tracker.mismatches == 0) begin
         $display("round_robin_task_scheduler test passed");
      end else begin
         $display("round_robin_task_scheduler test failed");
      end
      $finish;
   end

   // watchdog: too long without any transfer on either channel
   initial begin
      int unsigned quiet;
      quiet = 0;
      @(negedge reset);
      while (quiet < STALL_MAX) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("round_robin_task_scheduler test failed");
      $finish;
   end

endmodule
